// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character table of the base64 encoder.
package b64e_pkg;

  // Depth of the job queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [6:0] PadChar = 7'h3D;

  // Position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_e;

  // One classified byte: sextets to emit, then '=' pads
  typedef struct packed {
    logic [5:0] sext0;
    logic [5:0] sext1;
    logic       two_sext;  // emit sext1 after sext0
    logic [1:0] npad;      // '=' count after the sextets
    logic       fin;       // last byte of the message
  } job_t;

  // Sextet to ASCII: A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// Front end: takes bytes, tracks group phase and carry bits, builds jobs.
module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       data_byte_i,
  input  logic             final_byte_i,
  input  logic             q_full_i,
  output logic             job_valid_o,
  output b64e_pkg::job_t   job_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       carry_q, carry_d;
  logic             accept;

  assign accept      = push_i & ~q_full_i;
  assign job_valid_o = accept;

  // Phase and carry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PH_0;
      carry_q <= 4'd0;
    end else begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  // Split the byte into sextets and decide flush/padding
  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    job_o   = '0;
    job_o.fin = final_byte_i;
    case (phase_q)
      b64e_pkg::PH_1: begin
        job_o.sext0    = {carry_q[1:0], data_byte_i[7:4]};
        job_o.sext1    = {data_byte_i[3:0], 2'b00};
        job_o.two_sext = final_byte_i;
        job_o.npad     = final_byte_i ? 2'd1 : 2'd0;
        if (accept) begin
          phase_d = b64e_pkg::PH_2;
          carry_d = data_byte_i[3:0];
        end
      end
      b64e_pkg::PH_2: begin
        job_o.sext0    = {carry_q, data_byte_i[7:6]};
        job_o.sext1    = data_byte_i[5:0];
        job_o.two_sext = 1'b1;
        job_o.npad     = 2'd0;
        if (accept) begin
          phase_d = b64e_pkg::PH_0;
          carry_d = 4'd0;
        end
      end
      default: begin
        job_o.sext0    = data_byte_i[7:2];
        job_o.sext1    = {data_byte_i[1:0], 4'b0000};
        job_o.two_sext = final_byte_i;
        job_o.npad     = final_byte_i ? 2'd2 : 2'd0;
        if (accept) begin
          phase_d = b64e_pkg::PH_1;
          carry_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
    // Message end: back to the start of a group
    if (accept && final_byte_i) begin
      phase_d = b64e_pkg::PH_0;
      carry_d = 4'd0;
    end
  end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Small job queue between front and back.
module b64e_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  b64e_pkg::job_t   wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output b64e_pkg::job_t   rd_data_o,
  output logic             empty_o
);

  b64e_pkg::job_t                  slot_q [b64e_pkg::QDepth];
  logic [b64e_pkg::QAw-1:0]        wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::QCw-1:0]        cnt_q;
  logic                            do_wr, do_rd;

  assign full_o    = (cnt_q == b64e_pkg::QCw'(b64e_pkg::QDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == b64e_pkg::QAw'(b64e_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == b64e_pkg::QAw'(b64e_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: one character per cycle of a job into the free output register.
module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  b64e_pkg::job_t   job_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [6:0]       out_char_o,
  output logic             run_last_o,
  output logic             message_end_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [6:0] char_q, char_d;
  logic       last_q, last_d;
  logic       end_q, end_d;
  logic [1:0] last_idx;
  logic       load;
  logic       is_last;

  assign empty_o       = ~valid_q;
  assign out_char_o    = char_q;
  assign run_last_o    = last_q;
  assign message_end_o = end_q;

  // Output register frees when empty or being popped
  assign load     = (~valid_q | pop_i) & ~q_empty_i;
  assign last_idx = {1'b0, job_i.two_sext} + job_i.npad;
  assign is_last  = (idx_q == last_idx);
  assign q_pop_o  = load & is_last;

  // Pick the character at the current index of the head job
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q & ~pop_i;
    char_d  = char_q;
    last_d  = last_q;
    end_d   = end_q;
    if (load) begin
      valid_d = 1'b1;
      if (idx_q == 2'd0) begin
        char_d = b64e_pkg::b64_char(job_i.sext0);
      end else if (idx_q == 2'd1 && job_i.two_sext) begin
        char_d = b64e_pkg::b64_char(job_i.sext1);
      end else begin
        char_d = b64e_pkg::PadChar;
      end
      last_d = is_last;
      end_d  = is_last & job_i.fin;
      idx_d  = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// Base64 encoder, top level: front end, job queue and character back end.
//
// Standard padded base64 of a byte stream. Each pushed word is one byte;
// the byte flagged final closes the message, with the flush character and
// '=' padding where its group is incomplete. Results are characters, one
// popped word each, with run_last on the last character of a byte and
// message_end on the last of the message. The back end sends one character
// per cycle from its output register while that register is free and a job
// waits; a byte gives one or two characters (up to four on the final byte).
// A byte's first character passes the job queue, then the output register.
// A two-entry job queue keeps bytes coming while the back end is busy or stalled.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  b64e_pkg::job_t wr_job, rd_job;
  logic           wr_en, q_full, q_empty, q_pop;

  assign full = q_full;

  // Byte intake and classification
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .job_valid_o  (wr_en),
    .job_o        (wr_job)
  );

  // Job queue
  b64e_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_job),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (rd_job),
    .empty_o   (q_empty)
  );

  // Character emission
  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .job_i         (rd_job),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

// ===== hw/rtl/b64e_checker.sv =====
// Port-level checks of the base64 encoder, bound to the top level.
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [6:0] out_char_o,
  input logic       run_last_o,
  input logic       message_end_o
);

  // Nothing to pop while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // Message end only closes a byte's run
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && message_end_o) |-> run_last_o)
    else $error("message_end without run_last");

  // Every character is in the alphabet or a pad
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_char_o >= 7'h41 && out_char_o <= 7'h5A) ||
                (out_char_o >= 7'h61 && out_char_o <= 7'h7A) ||
                (out_char_o >= 7'h30 && out_char_o <= 7'h39) ||
                out_char_o == 7'h2B || out_char_o == 7'h2F ||
                out_char_o == b64e_pkg::PadChar))
    else $error("illegal output character");

  // A pad ends the run exactly when it ends the message
  a_pad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_char_o == b64e_pkg::PadChar) |-> (run_last_o == message_end_o))
    else $error("pad flags inconsistent");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(run_last_o)))
    else $error("stalled result changed");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_char_o    (out_char_o),
  .run_last_o    (run_last_o),
  .message_end_o (message_end_o)
);
